>>> rtl/charge_pulse_shaper_assert.svh
// Assertion macros for the charge pulse shaper checker.
// Used by rtl/cps_checker.sv; expects clk_i and rst_ni in scope.
`ifndef CHARGE_PULSE_SHAPER_ASSERT_SVH
`define CHARGE_PULSE_SHAPER_ASSERT_SVH

// Concurrent check that is switched off while reset is asserted.
`define CPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define CPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/cps_pkg.sv
// Shared types, constants and helpers of the charge pulse shaper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cps_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int DATA_W    = 32;
  localparam int DIV_W     = 16;
  localparam int ALPHA_W   = 16;
  localparam int RATIO_W   = 32;
  localparam int ENV_W     = RATIO_W + 1;
  localparam int SAT_W     = DATA_W + 3;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_DIVISOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATIO  = 2'd2;

  localparam logic [DIV_W-1:0]   NORM_DIVISOR_RST = 16'd20;
  localparam logic [ALPHA_W-1:0] FILTER_ALPHA_RST = 16'd3277;
  localparam logic [RATIO_W-1:0] DECAY_RATIO_RST  = 32'd4284243210;

  // Envelope of 1.0 in Q1.32.
  localparam logic [ENV_W-1:0] ENV_ONE = {1'b1, {RATIO_W{1'b0}}};

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Divider: quotient bits resolved per clock and clocks per division.
  localparam int DIV_STEPS   = 8;
  localparam int DIV_CYCLES  = DATA_W / DIV_STEPS;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

  // Datapath widths of the back end.
  localparam int DIFF_W = DATA_W + 1;
  localparam int PROD_W = DIFF_W + ALPHA_W + 1;
  localparam int PSH_W  = PROD_W - ALPHA_W;
  localparam int ENVP_W = 2 * RATIO_W;
  localparam int OUTP_W = DATA_W + RATIO_W + 1;
  localparam int OSH_W  = OUTP_W - RATIO_W;

  // Items in flight: queue entries, one in the back end, one in the output register.
  localparam int MAX_OUTSTANDING = QUEUE_DEPTH + 2;
  localparam int OUTST_W         = $clog2(MAX_OUTSTANDING + 1);

  typedef struct packed {
    logic                     first;
    logic signed [DATA_W-1:0] sum;
  } cps_item_t;

  typedef struct packed {
    logic [DIV_W-1:0]   norm_divisor;
    logic [ALPHA_W-1:0] filter_alpha;
    logic [RATIO_W-1:0] decay_ratio;
  } cps_cfg_t;

  // Clamp a wider signed value into the 32-bit signed range.
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SAT_W-1:0] v);
    logic ovf;
    ovf = (v[SAT_W-1:DATA_W-1] != {(SAT_W-DATA_W+1){v[SAT_W-1]}});
    if (!ovf) begin
      return v[DATA_W-1:0];
    end
    return v[SAT_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

endpackage

>>> rtl/cps_front.sv
// Front end of the charge pulse shaper: input handshake and running sum.
// Depends on cps_pkg; feeds cps_queue.
`timescale 1ns / 1ps

module cps_front import cps_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_value_i,
  input  logic                       first_sample_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output cps_item_t                  push_item_o
);

  logic signed [DATA_W-1:0] sum_q, sum_d;
  logic                     accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // A frame start restarts the sum; otherwise it accumulates with saturation.
  always_comb begin
    if (first_sample_i) begin
      sum_d = DATA_W'(sample_value_i);
    end else begin
      sum_d = sat_data(SAT_W'(sum_q) + SAT_W'(sample_value_i));
    end
  end

  assign push_o            = accept;
  assign push_item_o.first = first_sample_i;
  assign push_item_o.sum   = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (accept) begin
      sum_q <= sum_d;
    end
  end

endmodule

>>> rtl/cps_queue.sv
// Short FIFO of classified items between the front and the back end.
// Depends on cps_pkg.
`timescale 1ns / 1ps

module cps_queue import cps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cps_item_t push_item_i,
  input  logic      pop_i,
  output cps_item_t pop_item_o,
  output logic      full_o,
  output logic      empty_o
);

  cps_item_t          entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  count_q;

  assign full_o     = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_item_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> rtl/cps_div.sv
// Iterative unsigned divider, several quotient bits per clock.
// Depends on cps_pkg; used by cps_back.
`timescale 1ns / 1ps

module cps_div import cps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quotient_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DATA_W-1:0]    work_q, work_d;
  logic [DIV_W-1:0]     rem_q, rem_d, dvs_q;
  logic [DIV_W:0]       trial;
  logic                 last;

  assign last = (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1));

  // Restoring division: dividend bits shift out at the top, quotient bits in at the bottom.
  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    trial  = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial  = {rem_d, work_d[DATA_W-1]};
      work_d = {work_d[DATA_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d     = DIV_W'(trial - {1'b0, dvs_q});
        work_d[0] = 1'b1;
      end else begin
        rem_d = trial[DIV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
      // A zero divisor acts as one.
      dvs_q  <= (divisor_i == '0) ? DIV_W'(1) : divisor_i;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = work_q;

endmodule

>>> rtl/cps_back.sv
// Back end of the charge pulse shaper: division, low-pass filter, envelope, output register.
// Depends on cps_pkg and cps_div; pops items from cps_queue.
`timescale 1ns / 1ps

module cps_back import cps_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cps_cfg_t                 cfg_i,
  input  logic                     q_empty_i,
  input  cps_item_t                item_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] shaped_value_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MULF,
    ST_UPD,
    ST_MULO,
    ST_EMIT
  } state_e;

  state_e                    state_q;
  logic                      first_q, neg_q, out_valid_q;
  logic signed [DATA_W-1:0]  filt_q, shaped_q;
  logic [ENV_W-1:0]          env_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic [ENVP_W-1:0]         envp_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [OUTP_W-1:0]  outp_q;

  logic                      div_start, div_done;
  logic [DATA_W-1:0]         div_dividend, quot;
  logic signed [DIFF_W-1:0]  quot_s, diff_d;
  logic [ENVP_W-1:0]         envp_d;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [PSH_W-1:0]   prod_sh;
  logic signed [DATA_W-1:0]  filt_new, res;
  logic [ENV_W-1:0]          env_new;
  logic signed [OUTP_W-1:0]  outp_d;
  logic signed [OSH_W-1:0]   outp_sh;
  logic                      out_free;
  logic                      emit;

  assign pop_o        = (state_q == ST_IDLE) && !q_empty_i;
  assign div_start    = pop_o && !item_i.first;
  assign div_dividend = item_i.sum[DATA_W-1] ? DATA_W'(-item_i.sum) : DATA_W'(item_i.sum);

  cps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cfg_i.norm_divisor),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Quotient truncates toward zero: divide magnitudes, then restore the sign.
  assign quot_s  = neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign diff_d  = quot_s - DIFF_W'(filt_q);
  assign envp_d  = env_q[RATIO_W-1:0] * cfg_i.decay_ratio;
  assign prod_d  = diff_q * $signed({1'b0, cfg_i.filter_alpha});
  assign prod_sh = $signed(prod_q[PROD_W-1:ALPHA_W]);
  assign filt_new = sat_data(SAT_W'(filt_q) + SAT_W'(prod_sh));
  // An envelope of exactly 1.0 times the ratio is the ratio itself.
  assign env_new = env_q[ENV_W-1] ? {1'b0, cfg_i.decay_ratio}
                                  : {1'b0, envp_q[ENVP_W-1:RATIO_W]};
  assign outp_d  = filt_q * $signed({1'b0, env_q[RATIO_W-1:0]});
  assign outp_sh = $signed(outp_q[OUTP_W-1:RATIO_W]);
  assign res     = sat_data(SAT_W'(outp_sh));
  assign out_free = !out_valid_q || out_ready_i;
  // A finished result moves into the output register once it is empty or being taken.
  assign emit     = (state_q == ST_EMIT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_q     <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      shaped_q    <= '0;
      filt_q      <= '0;
      env_q       <= ENV_ONE;
      diff_q      <= '0;
      envp_q      <= '0;
      prod_q      <= '0;
      outp_q      <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            first_q <= item_i.first;
            neg_q   <= item_i.sum[DATA_W-1];
            if (item_i.first) begin
              filt_q  <= '0;
              env_q   <= ENV_ONE;
              state_q <= ST_EMIT;
            end else begin
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            diff_q  <= diff_d;
            envp_q  <= envp_d;
            state_q <= ST_MULF;
          end
        end
        ST_MULF: begin
          prod_q  <= prod_d;
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          filt_q  <= filt_new;
          env_q   <= env_new;
          state_q <= ST_MULO;
        end
        ST_MULO: begin
          outp_q  <= outp_d;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit) begin
            shaped_q <= first_q ? '0 : res;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign shaped_value_o = shaped_q;

endmodule

>>> rtl/charge_pulse_shaper.sv
// Top level of the charge pulse shaper: configuration registers, front end, queue, back end.
// Depends on cps_pkg, cps_front, cps_queue, cps_div and cps_back.
`timescale 1ns / 1ps

// Charge pulse shaper. Each input transfer carries one signed 16-bit sample and a
// frame-start flag, and produces exactly one 32-bit signed output transfer. The
// front end adds the sample to a saturating 32-bit running sum right at the input
// transfer and parks the result in a two-entry queue, so the input side keeps
// flowing while the back end works. The back end divides the sum by norm_divisor
// (truncating toward zero, a divisor of 0 acting as 1), runs the single-pole
// low-pass filter with the Q0.16 filter_alpha, advances the Q1.32 envelope by
// decay_ratio and scales the filter output by it. In the back end a regular sample
// is taken from the queue, passes through the divider (which resolves eight
// quotient bits per clock) and then through the filter product, the state update,
// the output product and the load of the output register. A frame-start sample
// resets the sum, filter and envelope and yields zero. The output register holds
// a finished result while the back end already takes the next item. Configuration
// writes are always accepted (cfg_ready_o is tied high); they should be issued only
// while no item is in flight. Writes to an index outside the register list are
// ignored. There is no clearing pass after reset.

module charge_pulse_shaper import cps_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_value_i,
  input  logic                       first_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [DATA_W-1:0]   shaped_value_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [DATA_W-1:0]          cfg_data_i
);

  cps_cfg_t  cfg_q;
  logic      push, pop, q_full, q_empty;
  cps_item_t push_item, pop_item;

  // The register file never stalls a write transfer.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.norm_divisor <= NORM_DIVISOR_RST;
      cfg_q.filter_alpha <= FILTER_ALPHA_RST;
      cfg_q.decay_ratio  <= DECAY_RATIO_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NORM_DIVISOR: cfg_q.norm_divisor <= cfg_data_i[DIV_W-1:0];
        CFG_FILTER_ALPHA: cfg_q.filter_alpha <= cfg_data_i[ALPHA_W-1:0];
        CFG_DECAY_RATIO:  cfg_q.decay_ratio  <= cfg_data_i[RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: accepts samples and keeps the running sum.
  cps_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_value_i (sample_value_i),
    .first_sample_i (first_sample_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .push_item_o    (push_item)
  );

  // Decouples the input rate from the multi-cycle back end.
  cps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // Back end: division, filter, envelope and the output register.
  cps_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_empty_i      (q_empty),
    .item_i         (pop_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .shaped_value_o (shaped_value_o)
  );

endmodule

>>> rtl/cps_checker.sv
// Port-level checks of the charge pulse shaper and their bind to the top level.
// Depends on cps_pkg and charge_pulse_shaper_assert.svh.
`timescale 1ns / 1ps
`include "charge_pulse_shaper_assert.svh"

module cps_checker import cps_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [DATA_W-1:0]   shaped_value_o
);

  logic [OUTST_W-1:0] outstanding_q;
  logic               in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // Items taken in but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      outstanding_q <= outstanding_q + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      outstanding_q <= outstanding_q - 1'b1;
    end
  end

  `CPS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result offered during reset")
  `CPS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(shaped_value_o), "stalled result changed")
  `CPS_ASSERT(a_no_orphan, out_valid_o |-> outstanding_q != '0, "result without a pending sample")
  `CPS_ASSERT(a_full_stall, outstanding_q == OUTST_W'(MAX_OUTSTANDING) |-> !in_ready_o, "sample taken with every slot in use")

endmodule

bind charge_pulse_shaper cps_checker u_cps_checker (.*);

>>> dv/charge_pulse_shaper_test.sv
// Self-checking testbench for the charge pulse shaper: directed table and random frames.
// Depends on cps_pkg and the charge_pulse_shaper RTL; a local predictor computes every output.
`timescale 1ns / 1ps

module charge_pulse_shaper_test;
  import cps_pkg::*;

  // The one register index that the block does not decode. Writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Idle and stall rates, in percent of cycles.
  localparam int IDLE_HEAVY = 63;
  localparam int IDLE_LIGHT = 9;

  localparam int RAND_PHASES     = 10;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int DIR_ROWS        = 27;
  // Idle cycles allowed at the end for a stray output to show up.
  localparam int TAIL_CYCLES     = 40;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_WRITE
  } row_kind_e;

  // One row of the directed table: either a sample transfer or a register write.
  // Where fixed is set, the expected output is typed in and used in place of the predictor's.
  typedef struct packed {
    row_kind_e                  kind;
    logic [CFG_IDX_W-1:0]       idx;
    logic [DATA_W-1:0]          data;
    logic signed [SAMPLE_W-1:0] smp;
    logic                       frm;
    logic                       fixed;
    logic signed [DATA_W-1:0]   fixed_val;
  } dir_row_t;

  logic                       clk_i          = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i     = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_value_i = '0;
  logic                       first_sample_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i    = 1'b0;
  logic signed [DATA_W-1:0]   shaped_value_o;
  logic                       cfg_valid_i    = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i    = '0;
  logic [DATA_W-1:0]          cfg_data_i     = '0;

  // Register copies that the predictor works with; they follow every accepted write.
  logic [DIV_W-1:0]   cur_divisor = NORM_DIVISOR_RST;
  logic [ALPHA_W-1:0] cur_alpha   = FILTER_ALPHA_RST;
  logic [RATIO_W-1:0] cur_decay   = DECAY_RATIO_RST;

  // Predictor state: running sum, low-pass output and Q1.32 envelope.
  logic signed [DATA_W-1:0] acc_sum  = '0;
  logic signed [DATA_W-1:0] lp_value = '0;
  logic [ENV_W-1:0]         env_gain = ENV_ONE;

  // Outputs still owed by the block, oldest first.
  logic signed [DATA_W-1:0] pending_shapes [$];

  int          error_count    = 0;
  int unsigned cycle_count    = 0;
  int          send_gap_pct   = 0;
  int          recv_stall_pct = 0;

  // These flags tell whether in_valid_i or cfg_valid_i was left high after the last
  // transfer, so that each is lowered once and never lowered and raised in one time step.
  bit feeding     = 1'b0;
  bit cfg_driving = 1'b0;

  dir_row_t dir_rows [DIR_ROWS];

  charge_pulse_shaper DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_value_i (sample_value_i),
    .first_sample_i (first_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .shaped_value_o (shaped_value_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // 8 ns clock period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Clamp a wide signed value into the 32-bit signed range.
  function automatic logic signed [DATA_W-1:0] clamp_s32(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[DATA_W-1:0];
  endfunction

  // Advances the predictor by one sample and returns the output the block must give for it.
  // All arithmetic runs in 64 bits, so none of the intermediate products can wrap.
  function automatic logic signed [DATA_W-1:0] shape_sample(
      input logic signed [SAMPLE_W-1:0] smp, input logic frm);
    longint     eff_div;
    longint     quo;
    longint     diff;
    longint     prod;
    logic [63:0] env_prod;
    if (frm) begin
      // A frame start reloads the sum with the sample, clears the filter and resets the envelope to 1.0.
      acc_sum  = smp;
      lp_value = '0;
      env_gain = ENV_ONE;
      return '0;
    end
    // A divisor of zero behaves as one.
    eff_div = (cur_divisor == '0) ? 64'sd1 : longint'(cur_divisor);
    acc_sum = clamp_s32(longint'(acc_sum) + longint'(smp));
    // Signed division truncates toward zero, as the block does.
    quo  = longint'(acc_sum) / eff_div;
    diff = quo - longint'(lp_value);
    // The arithmetic shift drops the low bits, which rounds toward minus infinity.
    prod     = diff * longint'(cur_alpha);
    lp_value = clamp_s32(longint'(lp_value) + (prod >>> ALPHA_W));
    // From exactly 1.0 the envelope steps straight to the ratio; below it, it is multiplied.
    if (env_gain >= ENV_ONE) begin
      env_gain = {1'b0, cur_decay};
    end else begin
      env_prod = {31'b0, env_gain} * {32'b0, cur_decay};
      env_gain = {1'b0, env_prod[63:32]};
    end
    prod = longint'(lp_value) * longint'({31'b0, env_gain});
    return clamp_s32(prod >>> RATIO_W);
  endfunction

  // Offers one sample, with a random gap in front of it, and books its expected output once
  // the transfer has taken place. in_valid_i stays high afterward, so that back-to-back
  // samples keep it up without a dip.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic frm,
                             input logic fixed, input logic signed [DATA_W-1:0] fixed_val);
    logic signed [DATA_W-1:0] predicted;
    if (cfg_driving) begin
      cfg_valid_i <= 1'b0;
      cfg_driving = 1'b0;
    end
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      feeding = 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_value_i <= smp;
    first_sample_i <= frm;
    feeding = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = shape_sample(smp, frm);
    pending_shapes.push_back(fixed ? fixed_val : predicted);
  endtask

  // Lowers the input valid and waits until every booked output has been taken, which
  // leaves the block with nothing in flight.
  task automatic drain_results();
    if (feeding) begin
      in_valid_i <= 1'b0;
      feeding = 1'b0;
    end
    while (pending_shapes.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // One register write. cfg_valid_i is left high so that a following write can reuse it;
  // the next sample transfer lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_driving = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_NORM_DIVISOR: cur_divisor = val[DIV_W-1:0];
      CFG_FILTER_ALPHA: cur_alpha   = val[ALPHA_W-1:0];
      CFG_DECAY_RATIO:  cur_decay   = val[RATIO_W-1:0];
      default: ;
    endcase
  endtask

  // Output side: every transfer is matched against the oldest booked output, and
  // out_ready_i is redrawn each cycle according to the current stall rate.
  always @(posedge clk_i) begin : result_check
    logic signed [DATA_W-1:0] want;
    if (out_valid_o && out_ready_i) begin
      if (pending_shapes.size() == 0) begin
        $error("shaped_value: no output expected, actual %0d", shaped_value_o);
        error_count++;
      end else begin
        want = pending_shapes.pop_front();
        if (shaped_value_o !== want) begin
          $error("shaped_value mismatch: expected %0d, actual %0d", want, shaped_value_o);
          error_count++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int       row;
    int       phase;
    int       sent;
    int       frame_len;
    int       k;
    logic     frm;
    logic signed [SAMPLE_W-1:0] smp;
    logic [DIV_W-1:0]   new_div;
    logic [ALPHA_W-1:0] new_alpha;
    logic [RATIO_W-1:0] new_decay;

    // Reset is applied as an event at time zero, so the reset flops see it at once.
    rst_ni <= 1'b0;

    // Directed table. The first rows run with no frame start at all, so the block must
    // treat its reset state as an open frame. Where the output is plainly zero (a frame
    // start, an all-zero sum, a sum that the division truncates to zero, an envelope
    // knocked to zero by a zero ratio) it is typed in.
    dir_rows = '{
      '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh8000, 1'b1, 1'b1, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh8000, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'shFFFF, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh0000, 1'b1, 1'b1, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh0000, 1'b0, 1'b1, '0},
      '{ROW_SAMPLE, '0, '0, 16'shFFFF, 1'b0, 1'b1, '0},
      '{ROW_WRITE, CFG_NORM_DIVISOR, 32'd0, '0, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sd12345, 1'b1, 1'b1, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh8000, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 1'b0, 1'b0, '0},
      '{ROW_WRITE, CFG_FILTER_ALPHA, 32'd0, '0, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sd1000, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, -16'sd1000, 1'b0, 1'b0, '0},
      '{ROW_WRITE, CFG_FILTER_ALPHA, 32'd65535, '0, 1'b0, 1'b0, '0},
      '{ROW_WRITE, CFG_DECAY_RATIO, 32'd0, '0, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sd5, 1'b0, 1'b1, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 1'b1, 1'b1, '0},
      '{ROW_SAMPLE, '0, '0, 16'sd100, 1'b0, 1'b1, '0},
      '{ROW_WRITE, CFG_DECAY_RATIO, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0},
      '{ROW_WRITE, CFG_UNUSED, 32'hDEAD_BEEF, '0, 1'b0, 1'b0, '0},
      '{ROW_WRITE, CFG_NORM_DIVISOR, 32'd65535, '0, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh8000, 1'b1, 1'b1, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh8000, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sd1, 1'b0, 1'b0, '0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (row = 0; row < DIR_ROWS; row++) begin
      if (dir_rows[row].kind == ROW_WRITE) begin
        drain_results();
        write_reg(dir_rows[row].idx, dir_rows[row].data);
      end else begin
        send_sample(dir_rows[row].smp, dir_rows[row].frm,
                    dir_rows[row].fixed, dir_rows[row].fixed_val);
      end
    end

    // Random part. Each phase takes a new register setting (reset values, extremes, then random
    // ones) and an idling pattern, then sends frames of random length and content. Most
    // frames open with a frame start; the rest continue the previous frame, and now and then
    // a frame start lands in the middle of one.
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      drain_results();
      case (phase)
        0: begin
          new_div   = NORM_DIVISOR_RST;
          new_alpha = FILTER_ALPHA_RST;
          new_decay = DECAY_RATIO_RST;
        end
        1: begin
          new_div   = 16'd0;
          new_alpha = 16'd65535;
          new_decay = 32'hFFFF_FFFF;
        end
        2: begin
          new_div   = 16'd65535;
          new_alpha = 16'd1;
          new_decay = 32'd0;
        end
        3: begin
          new_div   = 16'd1;
          new_alpha = 16'd0;
          new_decay = 32'h8000_0000;
        end
        4: begin
          new_div   = 16'd3;
          new_alpha = 16'd40000;
          new_decay = 32'hFFF0_0000;
        end
        default: begin
          // Small divisors keep the output off zero; the full range is drawn too.
          new_div   = $urandom_range(1) ? 16'($urandom_range(1, 64)) : 16'($urandom());
          new_alpha = 16'($urandom());
          new_decay = ($urandom_range(3) != 0) ?
                      32'hFFFF_FFFF - $urandom_range(0, 1 << 20) : $urandom();
        end
      endcase
      write_reg(CFG_NORM_DIVISOR, {16'b0, new_div});
      write_reg(CFG_FILTER_ALPHA, {16'b0, new_alpha});
      write_reg(CFG_DECAY_RATIO, new_decay);
      write_reg(CFG_UNUSED, $urandom());

      // Idling pattern: none, sender only, receiver only, then both lightly.
      case (phase % 4)
        0: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_gap_pct   = IDLE_HEAVY;
          recv_stall_pct = 0;
        end
        2: begin
          send_gap_pct   = 0;
          recv_stall_pct = IDLE_HEAVY;
        end
        default: begin
          send_gap_pct   = IDLE_LIGHT;
          recv_stall_pct = IDLE_LIGHT;
        end
      endcase

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        frame_len = $urandom_range(1, 30);
        for (k = 0; k < frame_len && sent < ITEMS_PER_PHASE; k++) begin
          frm = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
          case ($urandom_range(3))
            0: smp = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1: smp = 16'($urandom_range(255) - 128);
            default: smp = 16'($urandom());
          endcase
          send_sample(smp, frm, 1'b0, '0);
          sent++;
        end
      end
    end

    // Wind down: let every output through, then watch a little longer for strays.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
